/* hdl/i2cmru_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// i2cmru_pkg
// Shared types and constants of the I2C master register unit.
// ---------------------------------------------------------------------------
package i2cmru_pkg;

  // transaction kinds on the input channel
  typedef enum logic [1:0] {
    MODE_READ     = 2'd0,
    MODE_WRITE    = 2'd1,
    MODE_TX_EMPTY = 2'd2,
    MODE_RX_FULL  = 2'd3
  } mode_e;

  // completion event requested from the timing queue
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_TX_DONE = 2'd1,
    EV_RX_DONE = 2'd2
  } event_e;

  // register map
  localparam logic [15:0] OFF_IBMR = 16'h1680;
  localparam logic [15:0] OFF_IDBR = 16'h1688;
  localparam logic [15:0] OFF_ICR  = 16'h1690;
  localparam logic [15:0] OFF_ISR  = 16'h1698;
  localparam logic [15:0] OFF_ISAR = 16'h16A0;

  // control register bits
  localparam int unsigned CTL_START = 0;
  localparam int unsigned CTL_STOP  = 1;
  localparam int unsigned CTL_XFER  = 3;
  localparam int unsigned CTL_ENA   = 6;
  localparam int unsigned CTL_TXIE  = 8;
  localparam int unsigned CTL_RXIE  = 9;

  // status register bits
  localparam int unsigned STS_RW   = 0;
  localparam int unsigned STS_BUSY = 2;
  localparam int unsigned STS_TXE  = 6;
  localparam int unsigned STS_RXF  = 7;

  // write-one-to-clear field of the status register
  localparam logic [15:0] STS_W1C_MASK = 16'h07F0;

  // one result transaction
  typedef struct packed {
    logic [15:0] read_data;
    logic        irq;
    logic        send_start;
    logic        send_byte;
    logic [7:0]  byte_out;
    logic        receive_byte;
    logic        send_stop;
    event_e      schedule_event;
  } result_t;

endpackage : i2cmru_pkg
`default_nettype wire

/* hdl/i2c_master_register_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// i2c_master_register_unit
// Register front end of an I2C master: data, control, status and own-address
// registers, interrupt level and bus command outputs for each transaction.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | mode, reg_offset, write_value,
//          |           |                         | rx_byte, bus_lines
//  out     | output    | out_valid_o/out_stall_i | read_data, irq, send_start,
//          |           |                         | send_byte, byte_out,
//          |           |                         | receive_byte, send_stop,
//          |           |                         | schedule_event
//
// One transaction per clock cycle while in_stall_o is low: register state
// updates on the accepting edge, where the result is registered into the output
// register, or into a one-entry skid register behind it while a result is
// stalled; the skid register keeps the input side open for one more
// transaction, and in_stall_o rises only when both hold results.
// Reset clears the architectural registers and the valid flags of both result slots.
//
module i2c_master_register_unit
  import i2cmru_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [15:0] reg_offset_i,
  input  wire logic [15:0] write_value_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [1:0]  bus_lines_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      read_data_o,
  output logic             irq_o,
  output logic             send_start_o,
  output logic             send_byte_o,
  output logic [7:0]       byte_out_o,
  output logic             receive_byte_o,
  output logic             send_stop_o,
  output logic [1:0]       schedule_event_o
);

  // architectural registers
  logic [7:0]  data_buffer_q, data_buffer_d;
  logic [15:0] control_q, control_d;
  logic [15:0] status_q, status_d;
  logic [6:0]  own_addr_q, own_addr_d;
  logic        irq_q, irq_d;

  // result slots
  logic        out_valid_q, skid_valid_q;
  result_t     out_q, skid_q;
  result_t     res;

  logic        in_take, out_take;
  mode_e       mode;

  assign mode     = mode_e'(mode_i);
  assign in_take  = in_valid_i && !skid_valid_q;
  assign out_take = out_valid_q && !out_stall_i;

  // next-state and result logic for one transaction
  always_comb begin
    data_buffer_d = data_buffer_q;
    control_d     = control_q;
    status_d      = status_q;
    own_addr_d    = own_addr_q;
    irq_d         = irq_q;
    res           = '0;
    res.schedule_event = EV_NONE;

    unique case (mode)
      MODE_READ: begin
        unique case (reg_offset_i)
          OFF_IBMR: res.read_data = {14'd0, bus_lines_i};
          OFF_IDBR: res.read_data = {8'd0, data_buffer_q};
          OFF_ICR:  res.read_data = control_q;
          OFF_ISR:  res.read_data = status_q;
          OFF_ISAR: res.read_data = {9'd0, own_addr_q};
          default:  res.read_data = '0;
        endcase
      end
      MODE_WRITE: begin
        unique case (reg_offset_i)
          OFF_IDBR: data_buffer_d = write_value_i[7:0];
          OFF_ICR: begin
            // commands only when enabled and no byte transfer pending
            if (!control_q[CTL_XFER] && write_value_i[CTL_ENA]) begin
              if (write_value_i[CTL_START]) begin
                res.send_start     = 1'b1;
                status_d[STS_BUSY] = 1'b1;
                status_d[STS_RW]   = status_q[STS_RW] | data_buffer_q[0];
              end
              if (write_value_i[CTL_XFER]) begin
                if (status_q[STS_RW] && !write_value_i[CTL_START]) begin
                  data_buffer_d      = rx_byte_i;
                  res.receive_byte   = 1'b1;
                  res.schedule_event = EV_RX_DONE;
                end else begin
                  res.send_byte      = 1'b1;
                  res.byte_out       = data_buffer_q;
                  res.schedule_event = EV_TX_DONE;
                end
              end
              res.send_stop = write_value_i[CTL_STOP];
            end
            control_d = write_value_i;
            control_d[CTL_XFER] = write_value_i[CTL_XFER] | control_q[CTL_XFER];
          end
          OFF_ISR: begin
            status_d = status_q & ~(write_value_i & STS_W1C_MASK);
            irq_d = (control_q[CTL_TXIE] && status_d[STS_TXE]) ||
                    (control_q[CTL_RXIE] && status_d[STS_RXF]);
          end
          OFF_ISAR: own_addr_d = write_value_i[6:0];
          default: ;
        endcase
      end
      MODE_TX_EMPTY, MODE_RX_FULL: begin
        // transfer complete from the timing queue
        control_d[CTL_XFER] = 1'b0;
        if (mode == MODE_TX_EMPTY) begin
          status_d[STS_TXE] = 1'b1;
        end else begin
          status_d[STS_RXF] = 1'b1;
        end
        if (control_q[CTL_STOP]) begin
          status_d[STS_RW]   = 1'b0;
          status_d[STS_BUSY] = 1'b0;
        end
        irq_d = (control_d[CTL_TXIE] && status_d[STS_TXE]) ||
                (control_d[CTL_RXIE] && status_d[STS_RXF]);
      end
      default: ;
    endcase

    res.irq = irq_d;
  end

  // register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_buffer_q <= '0;
      control_q     <= '0;
      status_q      <= '0;
      own_addr_q    <= '0;
      irq_q         <= 1'b0;
    end else if (in_take) begin
      data_buffer_q <= data_buffer_d;
      control_q     <= control_d;
      status_q      <= status_d;
      own_addr_q    <= own_addr_d;
      irq_q         <= irq_d;
    end
  end

  // output register and skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign in_stall_o       = skid_valid_q;
  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_q.read_data;
  assign irq_o            = out_q.irq;
  assign send_start_o     = out_q.send_start;
  assign send_byte_o      = out_q.send_byte;
  assign byte_out_o       = out_q.byte_out;
  assign receive_byte_o   = out_q.receive_byte;
  assign send_stop_o      = out_q.send_stop;
  assign schedule_event_o = out_q.schedule_event;

`ifndef SYNTHESIS
  // skid slot is only filled behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a result while output register is empty");

  // a drained skid result moves into the output register
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid result not moved to output register");

  // byte output is zero unless a byte is sent
  a_byte_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.send_byte) |-> (out_q.byte_out == 8'd0))
    else $error("byte_out set without send_byte");

  // send and receive never in the same result, event code matches
  a_event_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!(out_q.send_byte && out_q.receive_byte) &&
                     ((out_q.schedule_event == EV_RX_DONE) == out_q.receive_byte) &&
                     ((out_q.schedule_event == EV_TX_DONE) == out_q.send_byte)))
    else $error("scheduled event does not match the byte command");
`endif

endmodule : i2c_master_register_unit
`default_nettype wire
